FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the grid path search checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/gdps_pkg.sv
// ----------------------------------------------------------------------------
// gdps_pkg
// shared types, constants and move tables of the grid path search engine
// ----------------------------------------------------------------------------
package gdps_pkg;

	localparam int COL_W  = 5;
	localparam int ROW_W  = 5;
	localparam int COLS   = 32;
	localparam int ROWS   = 32;
	localparam int CELL_W = COL_W + ROW_W;
	localparam int CELLS  = COLS * ROWS;
	localparam int CNT_W  = CELL_W + 1;
	localparam int DIST_W = 14;

	typedef enum logic [1:0] {
		OP_WALL   = 2'd0,
		OP_SEARCH = 2'd1,
		OP_PATH   = 2'd2,
		OP_CELL   = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALL,
		ST_RD,
		ST_RD_WAIT,
		ST_CLR,
		ST_START,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_REL_A,
		ST_REL_B,
		ST_REL_C,
		ST_REL_D,
		ST_REL_E,
		ST_PATH_RD,
		ST_PATH_STEP,
		ST_DONE
	} state_t;

	// per-cell search record
	typedef struct packed {
		logic              reached;
		logic              explored;
		logic [DIST_W-1:0] dcost;
		logic [2:0]        dir;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// column step of a move
	function automatic logic signed [1:0] move_dx(input logic [2:0] d);
		case (d)
			3'd0, 3'd4, 3'd5: move_dx = 2'sd1;
			3'd1, 3'd6, 3'd7: move_dx = -2'sd1;
			default:          move_dx = 2'sd0;
		endcase
	endfunction

	// row step of a move
	function automatic logic signed [1:0] move_dy(input logic [2:0] d);
		case (d)
			3'd2, 3'd4, 3'd6: move_dy = 2'sd1;
			3'd3, 3'd5, 3'd7: move_dy = -2'sd1;
			default:          move_dy = 2'sd0;
		endcase
	endfunction

	// straight moves cost 10, diagonal moves 14
	function automatic logic [3:0] move_cost(input logic [2:0] d);
		move_cost = d[2] ? 4'd14 : 4'd10;
	endfunction

endpackage

FILE: hdl/grid_dijkstra_path_search.sv
// ----------------------------------------------------------------------------
// grid_dijkstra_path_search
// 8-connected shortest path engine over a 32x32 wall grid
// ----------------------------------------------------------------------------
// channel | dir | tuser     | tdata
// s_*     | in  | opcode    | cell_x cell_y wall_value goal_x goal_y path_index
// m_*     | out | -         | found total_cost path_length explored_count
//         |     |           | node_x node_y cell_explored cell_wall
//
// wall write WALL, DONE; path or cell read RD, RD_WAIT, DONE; then output slot
// search: record clear, then per settled cell a minimum scan of all records
// through the node memory port plus relax steps REL_A to REL_E for each of
// up to 8 moves, then PATH_RD and PATH_STEP per node for the back-trace
// after reset a clearing pass over all 1024 cells runs before the first request
// one request at a time; the output register holds a result while stalled
// ----------------------------------------------------------------------------
module grid_dijkstra_path_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	// cell_x[4:0] cell_y[9:5] wall_value[10] goal_x[15:11] goal_y[20:16]
	// path_index[30:21], zero pad[31]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0] total_cost[14:1] path_length[25:15] explored_count[36:26]
	// node_x[41:37] node_y[46:42] cell_explored[47] cell_wall[48], pad[55:49]
	output logic [55:0] m_tdata
);

	localparam int CW = gdps_pkg::CELL_W;
	localparam int NW = gdps_pkg::NODE_W;
	localparam int KW = gdps_pkg::CNT_W;

	gdps_pkg::state_t  state_q, state_d;
	gdps_pkg::opcode_t op_q;

	logic [gdps_pkg::COL_W-1:0] cx_q, gx_q;
	logic [gdps_pkg::ROW_W-1:0] cy_q, gy_q;
	logic                       wv_q;
	logic [CW-1:0]              pidx_q;
	logic [KW-1:0]              cnt_q;

	// search bookkeeping
	gdps_pkg::node_t best_q;
	logic [CW-1:0]   best_idx_q;
	logic            any_q;
	logic [2:0]      dir_q;
	logic            blk_q;
	logic [CW-1:0]   pcur_q;
	logic            scan_vld_s1;
	logic [CW-1:0]   scan_idx_s1;

	// results
	logic                        found_q;
	logic [gdps_pkg::DIST_W-1:0] cost_q;
	logic [KW-1:0]               plen_q;
	logic [KW-1:0]               settled_q;
	logic [gdps_pkg::COL_W-1:0]  nx_q;
	logic [gdps_pkg::ROW_W-1:0]  ny_q;
	logic                        ce_q, cw_q;
	logic                        m_tvalid_q;
	logic [55:0]                 m_tdata_q;

	// memory ports
	logic          wall_we, wall_wd, wall_rd;
	logic [CW-1:0] wall_wa, wall_ra;
	logic          node_we;
	logic [CW-1:0] node_wa, node_ra;
	logic [NW-1:0] node_wd_bits, node_rd_bits;
	gdps_pkg::node_t node_wd, node_rd;
	logic          path_we;
	logic [CW-1:0] path_wa, path_wd, path_ra, path_rd;

	// neighbor geometry of the current move
	logic signed [gdps_pkg::COL_W+1:0] nbx;
	logic signed [gdps_pkg::ROW_W+1:0] nby;
	logic                              nb_in;
	logic [CW-1:0]                     nb_idx;
	logic [gdps_pkg::COL_W-1:0]        cur_x;
	logic [gdps_pkg::ROW_W-1:0]        cur_y;
	logic [gdps_pkg::DIST_W-1:0]       nd;
	logic                              blk_now;
	logic [gdps_pkg::COL_W-1:0]        prev_x;
	logic [gdps_pkg::ROW_W-1:0]        prev_y;
	logic [KW-1:0]                     path_ofs;
	logic                              out_free;

	gdps_ram #(.WIDTH(1), .ADDR_W(CW)) u_wall (
		.clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
		.raddr(wall_ra), .rdata(wall_rd)
	);

	gdps_ram #(.WIDTH(NW), .ADDR_W(CW)) u_node (
		.clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd_bits),
		.raddr(node_ra), .rdata(node_rd_bits)
	);

	gdps_ram #(.WIDTH(CW), .ADDR_W(CW)) u_path (
		.clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
		.raddr(path_ra), .rdata(path_rd)
	);

	assign node_wd_bits = node_wd;
	assign node_rd      = gdps_pkg::node_t'(node_rd_bits);

	// neighbor of the settled cell along dir_q
	assign cur_x  = best_idx_q[gdps_pkg::COL_W-1:0];
	assign cur_y  = best_idx_q[CW-1:gdps_pkg::COL_W];
	assign nbx    = $signed({2'b00, cur_x}) + (gdps_pkg::COL_W+2)'(gdps_pkg::move_dx(dir_q));
	assign nby    = $signed({2'b00, cur_y}) + (gdps_pkg::ROW_W+2)'(gdps_pkg::move_dy(dir_q));
	assign nb_in  = (nbx >= 0) && (nbx < gdps_pkg::COLS) && (nby >= 0) && (nby < gdps_pkg::ROWS);
	assign nb_idx = {nby[gdps_pkg::ROW_W-1:0], nbx[gdps_pkg::COL_W-1:0]};
	assign nd     = best_q.dcost + gdps_pkg::DIST_W'(gdps_pkg::move_cost(dir_q));
	assign blk_now = blk_q | (dir_q[2] & wall_rd);

	// predecessor of the back-trace cell
	assign prev_x = pcur_q[gdps_pkg::COL_W-1:0] - gdps_pkg::COL_W'(gdps_pkg::move_dx(node_rd.dir));
	assign prev_y = pcur_q[CW-1:gdps_pkg::COL_W] - gdps_pkg::ROW_W'(gdps_pkg::move_dy(node_rd.dir));

	// path is stored goal first
	assign path_ofs = plen_q - KW'(1) - {1'b0, pidx_q};
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == gdps_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdps_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		wall_we = 1'b0;
		wall_wa = {cy_q, cx_q};
		wall_wd = wv_q;
		wall_ra = nb_idx;
		node_we = 1'b0;
		node_wa = cnt_q[CW-1:0];
		node_wd = '0;
		node_ra = cnt_q[CW-1:0];
		path_we = 1'b0;
		path_wa = cnt_q[CW-1:0];
		path_wd = {gy_q, gx_q};
		path_ra = path_ofs[CW-1:0];
		case (state_q)
			gdps_pkg::ST_INIT: begin
				wall_we = 1'b1;
				wall_wa = cnt_q[CW-1:0];
				wall_wd = 1'b0;
				node_we = 1'b1;
				if (cnt_q == KW'(gdps_pkg::CELLS - 1)) begin
					state_d = gdps_pkg::ST_IDLE;
				end
			end
			gdps_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (gdps_pkg::opcode_t'(s_tuser))
						gdps_pkg::OP_WALL:   state_d = gdps_pkg::ST_WALL;
						gdps_pkg::OP_SEARCH: state_d = gdps_pkg::ST_CLR;
						default:             state_d = gdps_pkg::ST_RD;
					endcase
				end
			end
			gdps_pkg::ST_WALL: begin
				wall_we = 1'b1;
				state_d = gdps_pkg::ST_DONE;
			end
			gdps_pkg::ST_RD: begin
				wall_ra = {cy_q, cx_q};
				node_ra = {cy_q, cx_q};
				state_d = gdps_pkg::ST_RD_WAIT;
			end
			gdps_pkg::ST_RD_WAIT: begin
				state_d = gdps_pkg::ST_DONE;
			end
			gdps_pkg::ST_CLR: begin
				node_we = 1'b1;
				if (cnt_q == KW'(gdps_pkg::CELLS - 1)) begin
					state_d = gdps_pkg::ST_START;
				end
			end
			gdps_pkg::ST_START: begin
				node_we = 1'b1;
				node_wa = {cy_q, cx_q};
				node_wd = '{reached: 1'b1, explored: 1'b0, dcost: '0, dir: '0};
				state_d = gdps_pkg::ST_SCAN;
			end
			gdps_pkg::ST_SCAN: begin
				if (cnt_q == KW'(gdps_pkg::CELLS - 1)) begin
					state_d = gdps_pkg::ST_SCAN_END;
				end
			end
			gdps_pkg::ST_SCAN_END: begin
				state_d = gdps_pkg::ST_PICK;
			end
			gdps_pkg::ST_PICK: begin
				if (!any_q) begin
					state_d = gdps_pkg::ST_DONE;
				end else begin
					node_we = 1'b1;
					node_wa = best_idx_q;
					node_wd = best_q;
					node_wd.explored = 1'b1;
					if (best_idx_q == {gy_q, gx_q}) begin
						path_we = 1'b1;
						path_wa = '0;
						state_d = gdps_pkg::ST_PATH_RD;
					end else begin
						state_d = gdps_pkg::ST_REL_A;
					end
				end
			end
			gdps_pkg::ST_REL_A: begin
				if (nb_in) begin
					state_d = gdps_pkg::ST_REL_B;
				end else if (dir_q == 3'd7) begin
					state_d = gdps_pkg::ST_SCAN;
				end
			end
			gdps_pkg::ST_REL_B: begin
				wall_ra = {cur_y, nbx[gdps_pkg::COL_W-1:0]};
				state_d = gdps_pkg::ST_REL_C;
			end
			gdps_pkg::ST_REL_C: begin
				wall_ra = {nby[gdps_pkg::ROW_W-1:0], cur_x};
				state_d = gdps_pkg::ST_REL_D;
			end
			gdps_pkg::ST_REL_D: begin
				node_ra = nb_idx;
				state_d = gdps_pkg::ST_REL_E;
			end
			gdps_pkg::ST_REL_E: begin
				if (!blk_q && (!node_rd.reached || nd < node_rd.dcost)) begin
					node_we = 1'b1;
					node_wa = nb_idx;
					node_wd = '{reached: 1'b1, explored: node_rd.explored, dcost: nd, dir: dir_q};
				end
				state_d = (dir_q == 3'd7) ? gdps_pkg::ST_SCAN : gdps_pkg::ST_REL_A;
			end
			gdps_pkg::ST_PATH_RD: begin
				node_ra = pcur_q;
				if (pcur_q == {cy_q, cx_q} || cnt_q == KW'(gdps_pkg::CELLS)) begin
					state_d = gdps_pkg::ST_DONE;
				end else begin
					state_d = gdps_pkg::ST_PATH_STEP;
				end
			end
			gdps_pkg::ST_PATH_STEP: begin
				path_we = 1'b1;
				path_wd = {prev_y, prev_x};
				state_d = gdps_pkg::ST_PATH_RD;
			end
			gdps_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = gdps_pkg::ST_IDLE;
				end
			end
			default: state_d = gdps_pkg::ST_INIT;
		endcase
	end

	// control counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			plen_q      <= '0;
			settled_q   <= '0;
			any_q       <= 1'b0;
			scan_vld_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == gdps_pkg::ST_SCAN);
			// output slot loads on a free register, empties on accept
			if (state_q == gdps_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// running minimum over the scan
			if (scan_vld_s1 && node_rd.reached && !node_rd.explored &&
			    (!any_q || node_rd.dcost < best_q.dcost)) begin
				any_q <= 1'b1;
			end
			case (state_q)
				gdps_pkg::ST_INIT, gdps_pkg::ST_CLR, gdps_pkg::ST_SCAN: begin
					cnt_q <= (state_d == state_q) ? cnt_q + KW'(1) : '0;
				end
				gdps_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid && gdps_pkg::opcode_t'(s_tuser) == gdps_pkg::OP_SEARCH) begin
						found_q   <= 1'b0;
						plen_q    <= '0;
						settled_q <= '0;
					end
				end
				gdps_pkg::ST_START: begin
					any_q <= 1'b0;
				end
				gdps_pkg::ST_PICK: begin
					any_q <= 1'b0;
					if (any_q) begin
						settled_q <= settled_q + KW'(1);
						if (best_idx_q == {gy_q, gx_q}) begin
							found_q <= 1'b1;
							cnt_q   <= KW'(1);
						end
					end
				end
				gdps_pkg::ST_PATH_RD: begin
					if (state_d == gdps_pkg::ST_DONE) begin
						plen_q <= cnt_q;
					end
				end
				gdps_pkg::ST_PATH_STEP: begin
					cnt_q <= cnt_q + KW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan_vld_s1 && node_rd.reached && !node_rd.explored &&
		    (!any_q || node_rd.dcost < best_q.dcost)) begin
			best_q     <= node_rd;
			best_idx_q <= scan_idx_s1;
		end
		scan_idx_s1 <= cnt_q[CW-1:0];
		case (state_q)
			gdps_pkg::ST_IDLE: begin
				op_q   <= gdps_pkg::opcode_t'(s_tuser);
				cx_q   <= s_tdata[4:0];
				cy_q   <= s_tdata[9:5];
				wv_q   <= s_tdata[10];
				gx_q   <= s_tdata[15:11];
				gy_q   <= s_tdata[20:16];
				pidx_q <= s_tdata[30:21];
				nx_q   <= '0;
				ny_q   <= '0;
				ce_q   <= 1'b0;
				cw_q   <= 1'b0;
				if (s_tvalid && gdps_pkg::opcode_t'(s_tuser) == gdps_pkg::OP_SEARCH) begin
					cost_q <= '0;
				end
			end
			gdps_pkg::ST_RD_WAIT: begin
				if (op_q == gdps_pkg::OP_CELL) begin
					ce_q <= node_rd.explored;
					cw_q <= wall_rd;
				end else if ({1'b0, pidx_q} < plen_q) begin
					nx_q <= path_rd[gdps_pkg::COL_W-1:0];
					ny_q <= path_rd[CW-1:gdps_pkg::COL_W];
				end
			end
			gdps_pkg::ST_PICK: begin
				dir_q  <= '0;
				pcur_q <= best_idx_q;
				cost_q <= best_q.dcost;
			end
			gdps_pkg::ST_REL_A: begin
				if (!nb_in) begin
					dir_q <= dir_q + 3'd1;
				end
			end
			gdps_pkg::ST_REL_B: begin
				blk_q <= wall_rd;
			end
			gdps_pkg::ST_REL_C, gdps_pkg::ST_REL_D: begin
				blk_q <= blk_now;
			end
			gdps_pkg::ST_REL_E: begin
				dir_q <= dir_q + 3'd1;
			end
			gdps_pkg::ST_PATH_STEP: begin
				pcur_q <= {prev_y, prev_x};
			end
			gdps_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, cw_q, ce_q, ny_q, nx_q, settled_q,
					              found_q ? plen_q : KW'(0),
					              found_q ? cost_q : gdps_pkg::DIST_W'(0), found_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/gdps_ram.sv
// ----------------------------------------------------------------------------
// gdps_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module gdps_ram #(
	parameter int WIDTH  = 1,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/gdps_checker.sv
// ----------------------------------------------------------------------------
// gdps_checker
// port-level checks of the grid path search engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a stalled result stays offered and unchanged
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// no path means no cost and no length
	`ASSERT_IMPL(a_nopath, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[25:1] == 25'd0)

	// a found path holds at least the start node
	`ASSERT_IMPL(a_len, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[25:15] != 11'd0)

	// a found goal was settled, so the settled count is nonzero
	`ASSERT_IMPL(a_settled, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[36:26] != 11'd0)

endmodule

bind grid_dijkstra_path_search gdps_checker u_gdps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
